### rtl/lpm_pkg.sv
// Shared types and codes for the longest prefix match lookup block.
package lpm_pkg;

  // Command codes carried in the input item
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  // Input item: a table write or an address lookup
  typedef struct packed {
    logic        cmd;
    logic [3:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_prefix;
    logic [31:0] entry_mask;
    logic [31:0] entry_gateway;
    logic [3:0]  entry_port;
    logic [31:0] lookup_addr;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic        hit;
    logic [3:0]  match_index;
    logic [31:0] match_mask;
    logic [31:0] match_gateway;
    logic [3:0]  match_port;
  } out_item_t;

  // What travels from one cell to the next: the item and the best match so far
  typedef struct packed {
    logic      valid;
    in_item_t  item;
    out_item_t best;
  } lpm_flow_t;

endpackage

### rtl/lpm_cell.sv
// One routing table slot with its stage of the lookup chain.
module lpm_cell #(
  parameter int CELL_INDEX = 0,
  parameter int PORT_COUNT = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  lpm_pkg::lpm_flow_t flow_i,
  output lpm_pkg::lpm_flow_t flow_o
);
  import lpm_pkg::*;

  localparam logic [3:0] SlotId = 4'(CELL_INDEX);

  // Stored slot
  logic        ent_valid_q;
  logic [31:0] ent_prefix_q;
  logic [31:0] ent_mask_q;
  logic [31:0] ent_gw_q;
  logic [3:0]  ent_port_q;

  // Stage register toward the next cell
  logic      stg_valid_q;
  in_item_t  stg_item_q;
  out_item_t stg_best_q;
  out_item_t best_d;

  logic addr_match;
  logic take;
  logic wr_en;

  // Match and priority: strictly larger mask wins, so the lower slot keeps ties
  assign addr_match = ent_valid_q &&
      (((flow_i.item.lookup_addr ^ ent_prefix_q) & ent_mask_q) == 32'd0);
  assign take = (flow_i.item.cmd == CMD_LOOKUP) && addr_match &&
      (!flow_i.best.hit || (ent_mask_q > flow_i.best.match_mask));

  always_comb begin
    best_d = flow_i.best;
    if (take) begin
      best_d.hit           = 1'b1;
      best_d.match_index   = SlotId;
      best_d.match_mask    = ent_mask_q;
      best_d.match_gateway = ent_gw_q;
      best_d.match_port    = ent_port_q;
    end
  end

  // Write to this slot; a valid entry with an out of range port is dropped
  assign wr_en = adv_i && flow_i.valid && (flow_i.item.cmd == CMD_WRITE) &&
      (32'(flow_i.item.entry_index) == CELL_INDEX) &&
      (!flow_i.item.entry_valid || (32'(flow_i.item.entry_port) < PORT_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= 1'b0;
      stg_valid_q <= 1'b0;
    end else if (adv_i) begin
      stg_valid_q <= flow_i.valid;
      if (wr_en) begin
        ent_valid_q <= flow_i.item.entry_valid;
      end
    end
  end

  // Slot payload and stage payload
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_prefix_q <= flow_i.item.entry_prefix;
      ent_mask_q   <= flow_i.item.entry_mask;
      ent_gw_q     <= flow_i.item.entry_gateway;
      ent_port_q   <= flow_i.item.entry_port;
    end
    if (adv_i) begin
      stg_item_q <= flow_i.item;
      stg_best_q <= best_d;
    end
  end

  assign flow_o.valid = stg_valid_q;
  assign flow_o.item  = stg_item_q;
  assign flow_o.best  = stg_best_q;

endmodule

### rtl/longest_prefix_match_lookup.sv
// IPv4 longest prefix match routing table built as a chain of slot cells.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes two kinds of item:
// a write (cmd = 1) loads or removes one table slot, a lookup (cmd = 0)
// searches the table for the valid slot with the largest mask matching
// lookup_addr, lowest slot on equal masks. Every item yields exactly one
// result on the output channel (out_valid_o / out_stall_i / out_item_o);
// writes and misses give an all-zero result.
// Each item walks the chain through the stage register of every cell, one
// cell per table slot, then enters the result register.
// Items may follow each other in every cycle: throughput is one item per
// cycle unless the chain holds. Writes and lookups stay in order since both
// use the same chain. A result register sits after the last cell. While the
// receiver stalls a pending result, the whole chain holds and in_stall_o is
// raised. Reset empties the table and drops all items in flight.
module longest_prefix_match_lookup #(
  parameter int TABLE_ENTRIES = 16,
  parameter int PORT_COUNT    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lpm_pkg::out_item_t out_item_o
);
  import lpm_pkg::*;

  lpm_flow_t chain [TABLE_ENTRIES+1];
  logic      adv;
  logic      out_valid_q;
  out_item_t out_item_q;

  // Chain moves unless a finished result is still held by the receiver
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Chain head: new item with an empty best match
  assign chain[0].valid = in_valid_i;
  assign chain[0].item  = in_item_i;
  assign chain[0].best  = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lpm_cell #(
      .CELL_INDEX (g),
      .PORT_COUNT (PORT_COUNT)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .flow_i (chain[g]),
      .flow_o (chain[g+1])
    );
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[TABLE_ENTRIES].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && chain[TABLE_ENTRIES].valid) begin
      out_item_q <= chain[TABLE_ENTRIES].best;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A miss or a write reports all fields zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && !out_item_o.hit) |->
      (out_item_o.match_index == 4'd0 && out_item_o.match_mask == 32'd0 &&
       out_item_o.match_gateway == 32'd0 && out_item_o.match_port == 4'd0))
    else $error("miss result carries nonzero fields");

  // A winning slot exists in the table
  a_hit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_item_o.hit) |-> (32'(out_item_o.match_index) < TABLE_ENTRIES))
    else $error("hit reports slot beyond table");

  // Only valid entries with legal ports are stored, so a hit reports a legal port
  a_hit_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_item_o.hit) |-> (32'(out_item_o.match_port) < PORT_COUNT))
    else $error("hit reports port beyond range");

  // An item leaving the chain while it moves lands in the result register
  a_tail_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (chain[TABLE_ENTRIES].valid && adv) |=> out_valid_o)
    else $error("item lost at end of chain");

endmodule

### bench/longest_prefix_match_lookup_test.sv
// Self-checking testbench for the longest prefix match lookup table.
import lpm_pkg::*;

// Route table scoreboard: keeps its own copy of the table and the queue of expected results
class route_scoreboard;
  localparam int ENTRIES     = 16;
  localparam int PORTS       = 16;
  localparam int MAX_REPORTS = 60;

  logic [31:0] net_prefix [ENTRIES];
  logic [31:0] net_mask   [ENTRIES];
  logic [31:0] next_hop   [ENTRIES];
  logic [3:0]  out_port   [ENTRIES];
  logic        slot_used  [ENTRIES];

  out_item_t expected_routes [$];
  int        fail_count;

  function new();
    for (int i = 0; i < ENTRIES; i++) begin
      net_prefix[i] = '0;
      net_mask[i]   = '0;
      next_hop[i]   = '0;
      out_port[i]   = '0;
      slot_used[i]  = 1'b0;
    end
    fail_count = 0;
  endfunction

  // One line per mismatch, printing capped so a broken block cannot flood the log
  function void report(string what);
    if (fail_count < MAX_REPORTS) $display("MISMATCH: %s", what);
    fail_count++;
  endfunction

  // Apply an accepted item to the table copy and queue the result it must produce
  function void note_item(in_item_t it);
    out_item_t   res;
    logic [31:0] best_mask;
    bit          found;
    res       = '0;
    best_mask = '0;
    found     = 1'b0;
    if (it.cmd == CMD_WRITE) begin
      // Writes to slots past the table, or valid writes with an out-of-range port, are dropped
      if (int'(it.entry_index) < ENTRIES &&
          !(it.entry_valid && int'(it.entry_port) >= PORTS)) begin
        net_prefix[it.entry_index] = it.entry_prefix;
        net_mask[it.entry_index]   = it.entry_mask;
        next_hop[it.entry_index]   = it.entry_gateway;
        out_port[it.entry_index]   = it.entry_port;
        slot_used[it.entry_index]  = it.entry_valid;
      end
    end else begin
      // Largest mask wins; strict compare keeps the lowest slot on ties
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i] &&
            ((it.lookup_addr & net_mask[i]) == (net_prefix[i] & net_mask[i])) &&
            (!found || net_mask[i] > best_mask)) begin
          found             = 1'b1;
          best_mask         = net_mask[i];
          res.hit           = 1'b1;
          res.match_index   = 4'(i);
          res.match_mask    = net_mask[i];
          res.match_gateway = next_hop[i];
          res.match_port    = out_port[i];
        end
      end
    end
    expected_routes.push_back(res);
  endfunction

  // Compare an accepted result with the oldest expected one
  function void check_result(out_item_t got);
    out_item_t want;
    if (expected_routes.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = expected_routes.pop_front();
    if (got.hit !== want.hit)
      report($sformatf("hit got %b want %b", got.hit, want.hit));
    if (got.match_index !== want.match_index)
      report($sformatf("match_index got %0d want %0d", got.match_index, want.match_index));
    if (got.match_mask !== want.match_mask)
      report($sformatf("match_mask got %h want %h", got.match_mask, want.match_mask));
    if (got.match_gateway !== want.match_gateway)
      report($sformatf("match_gateway got %h want %h", got.match_gateway, want.match_gateway));
    if (got.match_port !== want.match_port)
      report($sformatf("match_port got %0d want %0d", got.match_port, want.match_port));
  endfunction
endclass

module longest_prefix_match_lookup_test;
  localparam int ENTRIES        = 16;
  localparam int WATCHDOG_TICKS = 2000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  route_scoreboard sb;
  int              idle_pct;

  // Network bases shared by random routes so that prefixes overlap
  localparam logic [31:0] NET_POOL [4] = '{32'h0A000000, 32'hC0A80000,
                                           32'hAC100000, 32'h0A0A0000};

  longest_prefix_match_lookup #(
    .TABLE_ENTRIES(ENTRIES),
    .PORT_COUNT   (16)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on run length
  initial begin
    #(WATCHDOG_TICKS);
    $display("Test completed with failures");
    $finish;
  end

  // Result side: random stalls, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) sb.check_result(out_item);
    out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
  end

  // Offer one item after a random idle gap and hold it until accepted
  task automatic send_item(in_item_t it);
    while ((idle_pct != 0) && ($urandom_range(99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic write_route(logic [3:0] idx, logic vld, logic [31:0] pfx, logic [31:0] msk,
                             logic [31:0] gw, logic [3:0] port);
    in_item_t it;
    it.cmd           = CMD_WRITE;
    it.entry_index   = idx;
    it.entry_valid   = vld;
    it.entry_prefix  = pfx;
    it.entry_mask    = msk;
    it.entry_gateway = gw;
    it.entry_port    = port;
    it.lookup_addr   = $urandom;
    send_item(it);
  endtask

  task automatic lookup_route(logic [31:0] addr);
    in_item_t it;
    it.cmd           = CMD_LOOKUP;
    it.entry_index   = 4'($urandom);
    it.entry_valid   = 1'($urandom);
    it.entry_prefix  = $urandom;
    it.entry_mask    = $urandom;
    it.entry_gateway = $urandom;
    it.entry_port    = 4'($urandom);
    it.lookup_addr   = addr;
    send_item(it);
  endtask

  // Random mask: mostly contiguous prefixes, some zero, all-ones or arbitrary
  function automatic logic [31:0] rand_mask();
    int len;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'hFFFFFFFF;
      default: begin
        len = $urandom_range(32);
        return (len == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - len));
      end
    endcase
  endfunction

  // Random item: writes build overlapping routes, most lookups aim at a stored route
  function automatic in_item_t rand_item();
    in_item_t    it;
    logic [3:0]  slot;
    int          pick;
    logic [31:0] msk;
    it.cmd           = ($urandom_range(99) < 30) ? CMD_WRITE : CMD_LOOKUP;
    it.entry_index   = 4'($urandom);
    it.entry_valid   = ($urandom_range(99) < 85);
    it.entry_prefix  = $urandom;
    it.entry_mask    = $urandom;
    it.entry_gateway = $urandom;
    it.entry_port    = 4'($urandom);
    it.lookup_addr   = $urandom;
    if (it.cmd == CMD_WRITE) begin
      msk           = rand_mask();
      it.entry_mask = msk;
      if ($urandom_range(99) < 80)
        it.entry_prefix = (NET_POOL[2'($urandom_range(3))] & msk) | ($urandom & ~msk);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        slot           = 4'($urandom_range(ENTRIES - 1));
        msk            = sb.net_mask[slot];
        it.lookup_addr = (sb.net_prefix[slot] & msk) | ($urandom & ~msk);
      end else if (pick < 85) begin
        it.lookup_addr = NET_POOL[2'($urandom_range(3))] | ($urandom & 32'h0000FFFF);
      end
    end
    return it;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    sb       = new();
    idle_pct = 22;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table misses
    lookup_route(32'h00000000);
    lookup_route(32'hFFFFFFFF);
    // Default route with stray prefix bits outside the mask
    write_route(4'd0, 1'b1, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 4'd15);
    lookup_route(32'h12345678);
    // Host route beats the default route
    write_route(4'd15, 1'b1, 32'hC0A80001, 32'hFFFFFFFF, 32'h0A000001, 4'd0);
    lookup_route(32'hC0A80001);
    lookup_route(32'hC0A80002);
    // /24 with stray host bits, then an equal mask in a higher slot
    write_route(4'd3, 1'b1, 32'hC0A800AA, 32'hFFFFFF00, 32'h0A000003, 4'd3);
    lookup_route(32'hC0A80001);
    lookup_route(32'hC0A800FF);
    write_route(4'd5, 1'b1, 32'hC0A80000, 32'hFFFFFF00, 32'h0A000005, 4'd5);
    lookup_route(32'hC0A80010);
    // Removing the lower slot hands the tie to the higher one
    write_route(4'd3, 1'b0, 32'h00000000, 32'h00000000, 32'h00000000, 4'd0);
    lookup_route(32'hC0A80010);
    // Non-contiguous mask
    write_route(4'd7, 1'b1, 32'h80000001, 32'h80000001, 32'hAAAAAAAA, 4'd10);
    lookup_route(32'h80000001);
    lookup_route(32'hFFFFFFFF);
    // Remove the default route, storing all-ones fields in the dead slot
    write_route(4'd0, 1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'd15);
    lookup_route(32'h01020304);
    // Host route for address zero
    write_route(4'd9, 1'b1, 32'h00000000, 32'hFFFFFFFF, 32'h55555555, 4'd15);
    lookup_route(32'h00000000);

    // Random traffic, with a stretch where neither side idles
    run_random(600);
    idle_pct = 0;
    run_random(300);
    idle_pct = 22;
    run_random(530);
    in_valid <= 1'b0;

    // Drain, then give stray results time to show up
    while (sb.expected_routes.size() != 0) @(posedge clk);
    repeat (4 * ENTRIES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
